/* rtl/core/stft_pkg.sv */
// Shared types, constants and twiddle generation for the spectrogram engine.
`default_nettype none
package stft_pkg;

  localparam int unsigned WindowDef = 64;
  localparam logic [6:0] HopReset = 7'd64;
  localparam logic signed [15:0] CoefReset = 16'sd32767;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned Q30One = 64'd1073741824;
  localparam logic signed [31:0] DbPerLog2Q24 = 32'sd50504453;
  localparam logic signed [16:0] LevelMax = 17'sd32767;
  localparam logic signed [16:0] LevelMin = -17'sd51200;
  localparam longint unsigned SinDiv [7] = '{6, 20, 42, 72, 110, 156, 210};
  localparam longint unsigned CosDiv [7] = '{2, 12, 30, 56, 90, 132, 182};

  typedef struct packed {
    logic               coef_we;
    logic [5:0]         coef_idx;
    logic signed [15:0] coef_val;
    logic               samp_we;
    logic signed [15:0] samp_val;
  } mem_wr_t;

  // {cos, sin} in Q24 for a quarter-wave angle x (Q30) and quadrant q
  function automatic logic [51:0] tw_pair(longint unsigned x, int unsigned q);
    longint unsigned x2, ts, tc;
    longint s, c, sq, cq;
    logic signed [25:0] cv, sv;
    x2 = (x * x) >> 30;
    ts = x;
    tc = Q30One;
    s = longint'(x);
    c = longint'(Q30One);
    for (int i = 1; i <= 7; i++) begin
      ts = ((ts * x2) >> 30) / SinDiv[i-1];
      tc = ((tc * x2) >> 30) / CosDiv[i-1];
      if ((i & 1) != 0) begin
        s = s - longint'(ts);
        c = c - longint'(tc);
      end else begin
        s = s + longint'(ts);
        c = c + longint'(tc);
      end
    end
    if (s < 0) s = 0;
    if (s > longint'(Q30One)) s = longint'(Q30One);
    if (c < 0) c = 0;
    if (c > longint'(Q30One)) c = longint'(Q30One);
    sq = (s + 32) >>> 6;
    cq = (c + 32) >>> 6;
    case (q)
      0: begin
        cv = 26'(cq);
        sv = 26'(sq);
      end
      1: begin
        cv = -26'(sq);
        sv = 26'(cq);
      end
      2: begin
        cv = -26'(cq);
        sv = -26'(sq);
      end
      default: begin
        cv = 26'(sq);
        sv = -26'(cq);
      end
    endcase
    return {cv, sv};
  endfunction

endpackage
`default_nettype wire

/* rtl/core/stft_log.sv */
// Iterative dB converter: magnitude normalization, log2 by squaring, dB scaling.
`default_nettype none
module stft_log import stft_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] re_i,
  input  wire logic signed [63:0] im_i,
  output logic                    done_o,
  output logic signed [16:0]      level_o
);

  typedef enum logic [3:0] {
    L_IDLE, L_SHIFT, L_SQA, L_SQB, L_SUM, L_NORM, L_SQR, L_ADJ, L_MUL, L_RND
  } lstate_e;

  lstate_e            state_q;
  logic [63:0]        a_q, b_q;
  logic [5:0]         sh_q, z_q;
  logic [62:0]        sum_q;
  logic [30:0]        m_q;
  logic [15:0]        frac_q;
  logic [3:0]         it_q;
  logic signed [63:0] prod_q;
  logic signed [16:0] level_q;
  logic               done_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [63:0]        abs_re, abs_im;
  logic [7:0]         expo;
  logic signed [31:0] l2;
  logic signed [63:0] rnd;
  logic signed [31:0] db;
  logic [31:0]        sq_t;

  assign abs_re = re_i[63] ? $unsigned(-re_i) : $unsigned(re_i);
  assign abs_im = im_i[63] ? $unsigned(-im_i) : $unsigned(im_i);
  assign expo   = {1'b0, sh_q, 1'b0} - {2'b00, z_q} - 8'd16;
  assign l2     = {{8{expo[7]}}, expo, frac_q};
  assign rnd    = prod_q + 64'sd2147483648;
  assign db     = rnd[63:32];
  assign sq_t   = prod_q[61:30];

  always_comb begin
    case (state_q)
      L_SQA: begin
        mul_a = $signed({1'b0, a_q[30:0]});
        mul_b = $signed({1'b0, a_q[30:0]});
      end
      L_SQB: begin
        mul_a = $signed({1'b0, b_q[30:0]});
        mul_b = $signed({1'b0, b_q[30:0]});
      end
      L_SQR: begin
        mul_a = $signed({1'b0, m_q});
        mul_b = $signed({1'b0, m_q});
      end
      L_MUL: begin
        mul_a = l2;
        mul_b = DbPerLog2Q24;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            a_q  <= abs_re;
            b_q  <= abs_im;
            sh_q <= '0;
            if (abs_re == '0 && abs_im == '0) begin
              level_q <= LevelMin;
              done_q  <= 1'b1;
            end else begin
              state_q <= L_SHIFT;
            end
          end
        end
        L_SHIFT: begin
          if (a_q[63:31] != '0 || b_q[63:31] != '0) begin
            a_q  <= a_q >> 1;
            b_q  <= b_q >> 1;
            sh_q <= sh_q + 6'd1;
          end else begin
            state_q <= L_SQA;
          end
        end
        L_SQA: begin
          prod_q  <= mul_p;
          state_q <= L_SQB;
        end
        L_SQB: begin
          sum_q   <= prod_q[62:0];
          prod_q  <= mul_p;
          state_q <= L_SUM;
        end
        L_SUM: begin
          sum_q   <= sum_q + prod_q[62:0];
          z_q     <= '0;
          state_q <= L_NORM;
        end
        L_NORM: begin
          if (!sum_q[62]) begin
            sum_q <= sum_q << 1;
            z_q   <= z_q + 6'd1;
          end else begin
            m_q     <= sum_q[62:32];
            it_q    <= '0;
            frac_q  <= '0;
            state_q <= L_SQR;
          end
        end
        L_SQR: begin
          prod_q  <= mul_p;
          state_q <= L_ADJ;
        end
        L_ADJ: begin
          if (sq_t[31]) begin
            m_q    <= sq_t[31:1];
            frac_q <= {frac_q[14:0], 1'b1};
          end else begin
            m_q    <= sq_t[30:0];
            frac_q <= {frac_q[14:0], 1'b0};
          end
          it_q <= it_q + 4'd1;
          if (it_q == 4'd15) state_q <= L_MUL;
          else state_q <= L_SQR;
        end
        L_MUL: begin
          prod_q  <= mul_p;
          state_q <= L_RND;
        end
        L_RND: begin
          if (db > 32'(LevelMax)) level_q <= LevelMax;
          else if (db < 32'(LevelMin)) level_q <= LevelMin;
          else level_q <= db[16:0];
          done_q  <= 1'b1;
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign level_o = level_q;

endmodule
`default_nettype wire

/* rtl/core/stft_frame.sv */
// Frame sequencer: sample and window stores, shared MAC for the DFT bins.
`default_nettype none
module stft_frame import stft_pkg::*; #(
  parameter int unsigned WINDOW = WindowDef,
  localparam int unsigned NW = $clog2(WINDOW)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mem_wr_t            mem_wr_i,
  input  wire logic [NW-1:0]      head_i,
  input  wire logic               start_i,
  output logic                    busy_o,
  output logic                    log_start_o,
  output logic signed [63:0]      re_o,
  output logic signed [63:0]      im_o,
  input  wire logic               log_done_i,
  input  wire logic               slot_free_i,
  output logic                    emit_o,
  output logic [NW-1:0]           bin_o,
  output logic                    last_o
);

  localparam logic [NW:0]   WinW  = (NW+1)'(WINDOW);
  localparam logic [NW-1:0] LastN = NW'(WINDOW - 1);
  localparam logic [NW-1:0] LastK = NW'(WINDOW / 2 - 1);

  typedef enum logic [2:0] {F_IDLE, F_MAC, F_TAIL, F_LSTART, F_LWAIT, F_EMIT} fstate_e;

  logic signed [25:0] cos_tab [WINDOW];
  logic signed [25:0] sin_tab [WINDOW];

  for (genvar m = 0; m < WINDOW; m++) begin : g_tw
    localparam int unsigned T = 4 * m;
    localparam int unsigned Q = (T / WINDOW) % 4;
    localparam longint unsigned Rem = T % WINDOW;
    localparam longint unsigned X = (HalfPiQ30 * Rem) / WINDOW;
    localparam logic [51:0] Tw = tw_pair(X, Q);
    assign cos_tab[m] = Tw[51:26];
    assign sin_tab[m] = Tw[25:0];
  end

  logic signed [15:0] coef_mem [WINDOW];
  logic [WINDOW-1:0]  coef_vld_q;
  logic signed [15:0] ring_mem [WINDOW];
  logic signed [15:0] samp_rd_q, coef_rd_q;

  fstate_e            state_q;
  logic [NW-1:0]      k_q, n_q, idx_q;
  logic [1:0]         ph_q;
  logic signed [31:0] v_q;
  logic signed [57:0] prod_q;
  logic signed [63:0] acc_re_q, acc_im_q;

  logic [NW:0]        pos_sum, idx_sum;
  logic [NW-1:0]      rd_pos, idx_nxt;
  logic signed [31:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [57:0] mul_p;
  logic               coef_hit;

  assign pos_sum  = {1'b0, head_i} + {1'b0, n_q};
  assign rd_pos   = (pos_sum >= WinW) ? NW'(pos_sum - WinW) : NW'(pos_sum);
  assign idx_sum  = {1'b0, idx_q} + {1'b0, k_q};
  assign idx_nxt  = (idx_sum >= WinW) ? NW'(idx_sum - WinW) : NW'(idx_sum);
  assign coef_hit = {1'b0, mem_wr_i.coef_idx} < 7'(WINDOW);

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.coef_we && coef_hit) coef_mem[mem_wr_i.coef_idx[NW-1:0]] <= mem_wr_i.coef_val;
    if (mem_wr_i.samp_we) ring_mem[head_i] <= mem_wr_i.samp_val;
    samp_rd_q <= ring_mem[rd_pos];
    coef_rd_q <= coef_vld_q[n_q] ? coef_mem[n_q] : CoefReset;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
    end else if (mem_wr_i.coef_we && coef_hit) begin
      coef_vld_q[mem_wr_i.coef_idx[NW-1:0]] <= 1'b1;
    end
  end

  always_comb begin
    case (ph_q)
      2'd1: begin
        mul_a = 32'(samp_rd_q);
        mul_b = 26'(coef_rd_q);
      end
      2'd3: begin
        mul_a = v_q;
        mul_b = sin_tab[idx_q];
      end
      default: begin
        mul_a = v_q;
        mul_b = cos_tab[idx_q];
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      k_q     <= '0;
      n_q     <= '0;
      ph_q    <= '0;
      idx_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (start_i) begin
            k_q      <= '0;
            n_q      <= '0;
            ph_q     <= '0;
            idx_q    <= '0;
            acc_re_q <= '0;
            acc_im_q <= '0;
            state_q  <= F_MAC;
          end
        end
        F_MAC: begin
          ph_q <= ph_q + 2'd1;
          case (ph_q)
            2'd0: if (n_q != '0) acc_im_q <= acc_im_q - 64'(prod_q);
            2'd1: v_q <= mul_p[31:0];
            2'd2: prod_q <= mul_p;
            default: begin
              acc_re_q <= acc_re_q + 64'(prod_q);
              prod_q   <= mul_p;
              if (n_q == LastN) begin
                state_q <= F_TAIL;
              end else begin
                n_q   <= n_q + 1'b1;
                idx_q <= idx_nxt;
              end
            end
          endcase
        end
        F_TAIL: begin
          acc_im_q <= acc_im_q - 64'(prod_q);
          state_q  <= F_LSTART;
        end
        F_LSTART: state_q <= F_LWAIT;
        F_LWAIT: if (log_done_i) state_q <= F_EMIT;
        F_EMIT: begin
          if (slot_free_i) begin
            if (k_q == LastK) begin
              state_q <= F_IDLE;
            end else begin
              k_q      <= k_q + 1'b1;
              n_q      <= '0;
              ph_q     <= '0;
              idx_q    <= '0;
              acc_re_q <= '0;
              acc_im_q <= '0;
              state_q  <= F_MAC;
            end
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign busy_o      = state_q != F_IDLE;
  assign log_start_o = state_q == F_LSTART;
  assign re_o        = acc_re_q;
  assign im_o        = acc_im_q;
  assign emit_o      = (state_q == F_EMIT) && slot_free_i;
  assign bin_o       = k_q;
  assign last_o      = k_q == LastK;

endmodule
`default_nettype wire

/* rtl/core/stft_log_magnitude.sv */
// Top level of the streaming spectrogram engine with dB magnitude output.
//
// Input stream: one transfer is either a window coefficient write (tuser 0) or
// one sample push (tuser 1). Coefficient writes and pushes that start no frame
// leave s_axis_tready high. Once WINDOW samples are in, and then every
// hop_length samples, the pushing transfer starts a frame: the ring of the
// last WINDOW samples is windowed and transformed bin by bin with one shared
// multiplier, then each bin passes an iterative dB conversion before it is
// stored. A frame emits WINDOW/2 results in bin order, tlast on the final bin.
// s_axis_tready is low while a frame runs; it rises as soon as the final bin
// sits in the output register. A stalled m_axis_tready holds the current
// result and pauses the frame before the next bin is stored.
// Reset empties the ring, zeroes the counters, restores the rectangular
// window and sets hop_length to 64. cfg_we_i writes hop_length at once and is
// meant for idle periods; a hop_length of zero acts as one.
`default_nettype none
module stft_log_magnitude import stft_pkg::*; #(
  parameter int unsigned WINDOW = WindowDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // coef_index[5:0], coef_value[21:6], sample[37:22]
  input  wire logic        s_axis_tuser,  // func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // bin_index[4:0], level_db[21:5]
  output logic             m_axis_tlast
);

  localparam int unsigned NW = $clog2(WINDOW);
  localparam int unsigned FW = $clog2(WINDOW + 1);
  localparam logic [FW-1:0] FillFull = FW'(WINDOW);
  localparam logic [NW-1:0] HeadLast = NW'(WINDOW - 1);

  logic [6:0]         hop_len_q, hop_q, hop_nxt, hop_eff;
  logic [FW-1:0]      fill_q;
  logic [NW-1:0]      head_q;
  logic               accept, push, start, busy, slot_free, emit, last, log_start, log_done;
  logic [NW-1:0]      bin;
  logic signed [63:0] re, im;
  logic signed [16:0] level;
  mem_wr_t            mem_wr;

  logic               out_valid_q, out_last_q;
  logic [4:0]         out_bin_q;
  logic signed [16:0] out_level_q;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push          = accept && s_axis_tuser;
  assign hop_nxt       = hop_q + 7'd1;
  assign hop_eff       = (hop_len_q == '0) ? 7'd1 : hop_len_q;
  assign start         = push && ((fill_q < FillFull) ? (fill_q + 1'b1 == FillFull)
                                                      : (hop_nxt >= hop_eff));

  assign mem_wr.coef_we  = accept && !s_axis_tuser;
  assign mem_wr.coef_idx = s_axis_tdata[5:0];
  assign mem_wr.coef_val = s_axis_tdata[21:6];
  assign mem_wr.samp_we  = push;
  assign mem_wr.samp_val = s_axis_tdata[37:22];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_len_q <= HopReset;
      hop_q     <= '0;
      fill_q    <= '0;
      head_q    <= '0;
    end else begin
      if (cfg_we_i) hop_len_q <= cfg_wdata_i;
      if (push) begin
        head_q <= (head_q == HeadLast) ? '0 : head_q + 1'b1;
        if (fill_q < FillFull) begin
          fill_q <= fill_q + 1'b1;
          if (fill_q + 1'b1 == FillFull) hop_q <= '0;
        end else begin
          hop_q <= (hop_nxt >= hop_eff) ? '0 : hop_nxt;
        end
      end
    end
  end

  stft_frame #(.WINDOW(WINDOW)) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mem_wr_i    (mem_wr),
    .head_i      (head_q),
    .start_i     (start),
    .busy_o      (busy),
    .log_start_o (log_start),
    .re_o        (re),
    .im_o        (im),
    .log_done_i  (log_done),
    .slot_free_i (slot_free),
    .emit_o      (emit),
    .bin_o       (bin),
    .last_o      (last)
  );

  stft_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .re_i    (re),
    .im_i    (im),
    .done_o  (log_done),
    .level_o (level)
  );

  assign slot_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_bin_q   <= 5'(bin);
      out_level_q <= level;
      out_last_q  <= last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_level_q, out_bin_q};
  assign m_axis_tlast  = out_last_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || m_axis_tready))
    else $error("result stored over an untaken result");
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy)
    else $error("frame start did not engage the sequencer");
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull)
    else $error("fill count beyond window");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !start)
    else $error("frame start while a frame runs");

endmodule
`default_nettype wire

/* verif/stft_log_magnitude_tb.sv */
// Self-checking testbench for the streaming dB spectrogram engine.
`timescale 1ns / 100ps
module stft_log_magnitude_tb;

  localparam int Win = 64;
  localparam int Bins = Win / 2;
  localparam logic FuncCoef = 1'b0;
  localparam logic FuncSample = 1'b1;
  localparam int CycleLimit = 4000000;
  localparam int SettleCycles = 300;
  localparam longint unsigned QOne = 64'd1073741824;
  localparam longint unsigned HalfPi = 64'd1686629713;
  localparam longint DbPerOctave = 64'sd50504453;
  localparam longint LvlMax = 32767;
  localparam longint LvlMin = -51200;

  typedef struct {
    logic               func;
    logic [5:0]         coef_index;
    logic signed [15:0] coef_value;
    logic signed [15:0] sample;
  } stream_item_t;

  typedef struct {
    logic [4:0]         bin_index;
    logic signed [16:0] level_db;
    logic               last;
  } bin_level_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  stft_log_magnitude dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  stream_item_t pending_q[$];
  bin_level_t   spectrum_q[$];
  stream_item_t held_item;
  int           mismatches = 0;
  int           cycles = 0;
  bit           idle_on = 1'b1;
  int           in_gap = 0;
  int           out_gap = 0;

  logic signed [15:0] win_coef[Win];
  logic signed [15:0] ring[Win];
  logic [5:0]         ring_head;
  int                 fill_count;
  logic [6:0]         hop_count;
  logic [6:0]         hop_len;
  longint             cos_tab[Win];
  longint             sin_tab[Win];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // quarter-wave Taylor series, Q30 in, Q24 twiddles out
  task automatic build_twiddles();
    longint unsigned x, x2, ts, tc, sm, cm;
    longint s, c;
    int t, q;
    for (int m = 0; m < Win; m++) begin
      t = 4 * m;
      q = (t / Win) & 3;
      x = (HalfPi * longint'(t % Win)) / Win;
      x2 = (x * x) >> 30;
      ts = x;
      tc = QOne;
      s = longint'(x);
      c = longint'(QOne);
      for (int i = 1; i <= 7; i++) begin
        ts = ((ts * x2) >> 30) / longint'((2 * i) * (2 * i + 1));
        tc = ((tc * x2) >> 30) / longint'((2 * i - 1) * (2 * i));
        if (i % 2 == 1) begin
          s -= longint'(ts);
          c -= longint'(tc);
        end else begin
          s += longint'(ts);
          c += longint'(tc);
        end
      end
      if (s < 0) s = 0;
      if (s > longint'(QOne)) s = longint'(QOne);
      if (c < 0) c = 0;
      if (c > longint'(QOne)) c = longint'(QOne);
      sm = (longint'(s) + 32) >> 6;
      cm = (longint'(c) + 32) >> 6;
      case (q)
        0: begin cos_tab[m] = cm; sin_tab[m] = sm; end
        1: begin cos_tab[m] = -longint'(sm); sin_tab[m] = cm; end
        2: begin cos_tab[m] = -longint'(cm); sin_tab[m] = -longint'(sm); end
        default: begin cos_tab[m] = sm; sin_tab[m] = -longint'(cm); end
      endcase
    end
  endtask

  function automatic logic signed [16:0] db_level(longint re, longint im);
    longint unsigned a, b, sum, m;
    int sh, e;
    longint l2, db;
    longint unsigned biased;
    logic [15:0] frac;
    a = (re < 0) ? longint'(-re) : longint'(re);
    b = (im < 0) ? longint'(-im) : longint'(im);
    if (a == 0 && b == 0) return 17'(LvlMin);
    sh = 0;
    while (a >= (64'd1 << 31) || b >= (64'd1 << 31)) begin
      a >>= 1;
      b >>= 1;
      sh++;
    end
    sum = a * a + b * b;
    e = 0;
    while (e < 63 && (sum >> (e + 1)) != 0) e++;
    m = (e >= 30) ? (sum >> (e - 30)) : (sum << (30 - e));
    frac = '0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        frac[0] = 1'b1;
      end
    end
    l2 = longint'(e + 2 * sh - 78) * 65536 + longint'(frac);
    biased = longint'(l2 * DbPerOctave + (longint'(1) << 52) + (longint'(1) << 31));
    db = longint'(biased >> 32) - (longint'(1) << 20);
    if (db > LvlMax) db = LvlMax;
    if (db < LvlMin) db = LvlMin;
    return 17'(db);
  endfunction

  task automatic predict_frame();
    longint v[Win];
    longint re, im;
    bin_level_t r;
    for (int n = 0; n < Win; n++)
      v[n] = longint'(ring[(int'(ring_head) + n) % Win]) * longint'(win_coef[n]);
    for (int k = 0; k < Bins; k++) begin
      re = 0;
      im = 0;
      for (int n = 0; n < Win; n++) begin
        re += v[n] * cos_tab[(k * n) % Win];
        im -= v[n] * sin_tab[(k * n) % Win];
      end
      r.bin_index = 5'(k);
      r.level_db = db_level(re, im);
      r.last = (k == Bins - 1);
      spectrum_q.insert(spectrum_q.size(), r);
    end
  endtask

  task automatic predict_transfer(stream_item_t it);
    logic [6:0] hop;
    if (it.func == FuncCoef) begin
      win_coef[it.coef_index] = it.coef_value;
      return;
    end
    ring[ring_head] = it.sample;
    ring_head = ring_head + 6'd1;
    if (fill_count < Win) begin
      fill_count++;
      if (fill_count == Win) begin
        hop_count = '0;
        predict_frame();
      end
      return;
    end
    hop = (hop_len == 0) ? 7'd1 : hop_len;
    hop_count = hop_count + 7'd1;
    if (hop_count >= hop) begin
      hop_count = '0;
      predict_frame();
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    logic nv;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_transfer(held_item);
      if (!s_axis_tvalid || s_axis_tready) begin
        nv = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_q.size() > 0) begin
          held_item = pending_q[0];
          pending_q.delete(0);
          s_axis_tdata <= {2'b00, held_item.sample, held_item.coef_value,
                           held_item.coef_index};
          s_axis_tuser <= held_item.func;
          nv = 1'b1;
          in_gap = pick_gap();
        end
        s_axis_tvalid <= nv;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    bin_level_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t timeout", $realtime);
      $display("end of test: mismatches");
      $finish;
    end else if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (spectrum_q.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: bin %0d level %0d last %0b", $realtime,
                   m_axis_tdata[4:0], $signed(m_axis_tdata[21:5]), m_axis_tlast);
        end else begin
          want = spectrum_q[0];
          spectrum_q.delete(0);
          if (m_axis_tdata[4:0] !== want.bin_index) begin
            mismatches++;
            $display("%0t bin_index: expected %0d actual %0d", $realtime,
                     want.bin_index, m_axis_tdata[4:0]);
          end
          if ($signed(m_axis_tdata[21:5]) !== want.level_db) begin
            mismatches++;
            $display("%0t level_db bin %0d: expected %0d actual %0d", $realtime,
                     want.bin_index, want.level_db, $signed(m_axis_tdata[21:5]));
          end
          if (m_axis_tlast !== want.last) begin
            mismatches++;
            $display("%0t last bin %0d: expected %0b actual %0b", $realtime,
                     want.bin_index, want.last, m_axis_tlast);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        out_gap = pick_gap();
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic add_coef(int idx, int val);
    stream_item_t it;
    it.func = FuncCoef;
    it.coef_index = 6'(idx);
    it.coef_value = 16'(val);
    it.sample = 16'($urandom);
    pending_q.insert(pending_q.size(), it);
  endtask

  task automatic add_sample(int val);
    stream_item_t it;
    it.func = FuncSample;
    it.coef_index = 6'($urandom);
    it.coef_value = 16'($urandom);
    it.sample = 16'(val);
    pending_q.insert(pending_q.size(), it);
  endtask

  function automatic int rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return int'($signed(16'($urandom)));
    if (r < 8) return $urandom_range(0, 255) - 128;
    return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
  endfunction

  task automatic drain_idle();
    while (pending_q.size() > 0 || s_axis_tvalid || spectrum_q.size() > 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_hop(int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 7'(val);
    hop_len = 7'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int hop, int count);
    write_hop(hop);
    idle_on = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_coef($urandom_range(0, Win - 1), rand_value());
      else
        add_sample(rand_value());
    end
    drain_idle();
  endtask

  initial begin
    for (int i = 0; i < Win; i++) win_coef[i] = 16'sd32767;
    ring_head = '0;
    fill_count = 0;
    hop_count = '0;
    hop_len = 7'd64;
    build_twiddles();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_coef(0, -32768);
    add_coef(63, 32767);
    add_coef(21, 0);
    add_coef(42, -1);
    for (int i = 0; i < Win; i++) add_sample(0);
    drain_idle();

    write_hop(1);
    add_sample(32767);
    add_sample(-32768);
    add_sample(-1);
    drain_idle();
    write_hop(0);
    add_coef(5, 21845);
    add_sample(12345);
    add_sample(-54);
    drain_idle();
    write_hop(64);
    for (int i = 0; i < 10; i++) add_sample(rand_value());
    drain_idle();
    write_hop(5);
    add_sample(777);
    drain_idle();

    random_phase(64, 130);
    random_phase(7, 90);
    random_phase(33, 80);
    random_phase($urandom_range(8, 64), 90);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
